@@ src/accel_tilt_angle_filter_macros.svh @@
// assertion macros for the checker file
`ifndef ACCEL_TILT_ANGLE_FILTER_MACROS_SVH
`define ACCEL_TILT_ANGLE_FILTER_MACROS_SVH

// clocked on aclk, quiet while aresetn is low
`define ATF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked on aclk, also checked during reset
`define ATF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/atf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package atf_pkg;

    localparam int SAMPLE_BITS_DEF  = 13;
    localparam int CORDIC_STEPS_DEF = 16;

    // angle format: signed degrees * 256
    localparam int ANG_W     = 17;
    localparam int ANG_LIMIT = 46080;

    // blend weight register
    localparam int           W_W     = 9;
    localparam logic [8:0]   W_RESET = 9'd241;
    localparam logic [8:0]   W_MAX   = 9'd256;

    // cordic angle accumulator: degrees * 65536
    localparam int Z_W          = 25;
    localparam int ATAN_TAB_LEN = 24;
    localparam int ATAN_IDX_W   = 5;

    // shared multiplier operand width
    localparam int MUL_W = 18;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 25'sd2949120;
            5'd1:    val = 25'sd1740967;
            5'd2:    val = 25'sd919879;
            5'd3:    val = 25'sd466945;
            5'd4:    val = 25'sd234379;
            5'd5:    val = 25'sd117304;
            5'd6:    val = 25'sd58666;
            5'd7:    val = 25'sd29335;
            5'd8:    val = 25'sd14668;
            5'd9:    val = 25'sd7334;
            5'd10:   val = 25'sd3667;
            5'd11:   val = 25'sd1833;
            5'd12:   val = 25'sd917;
            5'd13:   val = 25'sd458;
            5'd14:   val = 25'sd229;
            5'd15:   val = 25'sd115;
            5'd16:   val = 25'sd57;
            5'd17:   val = 25'sd29;
            5'd18:   val = 25'sd14;
            5'd19:   val = 25'sd7;
            5'd20:   val = 25'sd4;
            5'd21:   val = 25'sd2;
            5'd22:   val = 25'sd1;
            default: val = 25'sd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ src/atf_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// digit-by-digit integer square root, one root bit per cycle
module atf_isqrt #(
    parameter int ROOT_W = 21
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output logic                       done,
    output logic [ROOT_W-1:0]          root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = take ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], take};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ src/accel_tilt_angle_filter.sv @@
// from input transaction to m_axis_tvalid, each sample runs squares, square root, cordic,
//          blend and finish for roll, again for pitch, then passes the pair to the output register
// flow: a new sample is taken only after the last pair is in the output register; the pace is
//          set by the bit-serial square root and the one-iteration-per-cycle cordic, run per angle
// reset: synchronous active-low aresetn clears angles and offsets, loads weight 241,
//          drops m_axis_tvalid and returns to idle
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_angle_filter
    import atf_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // weight register write
    input  wire logic                                  cfg_we,
    input  wire logic [W_W-1:0]                        cfg_wdata,
    // sample input: accel_x, accel_y, accel_z from bit 0 up, zero padded
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // calibrate
    input  wire logic                                  s_axis_tuser,
    // angle output: roll_deg, pitch_deg from bit 0 up, zero padded
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [((2*ANG_W+7)/8)*8-1:0]               m_axis_tdata
);

    // widths that follow from the sample size
    localparam int S           = SAMPLE_BITS;
    localparam int SQ_W        = 2 * S;           // sum of two squares
    localparam int ROOT_W      = S + 8;           // sqrt of (sum << 16)
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int CW          = S + 11;          // cordic x/y with gain headroom
    localparam int IDX_W       = $clog2(CORDIC_STEPS);
    localparam int OUT_W       = ((2*ANG_W+7)/8)*8;
    // blend arithmetic
    localparam int BL_W        = ANG_W + W_W + 2; // 256*old + w*(fresh-old) + 128
    localparam int RND_W       = BL_W - 8;
    localparam int DIF_W       = RND_W + 1;

    // sequencer: each sample runs the sequence twice, roll first then pitch
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQ_A   = 8'b0000_0010,  // first square
        ST_SQ_B   = 8'b0000_0100,  // second square, kick the square root
        ST_SQRT   = 8'b0000_1000,  // wait for the root, load cordic
        ST_CORDIC = 8'b0001_0000,  // one vectoring iteration per cycle
        ST_BLEND  = 8'b0010_0000,  // round angle, weight times difference
        ST_FINISH = 8'b0100_0000,  // add, round, remove offset, saturate, store
        ST_OUT    = 8'b1000_0000   // hand the pair to the output register
    } state_t;

    state_t state_reg, state_next;

    // captured sample
    logic signed [S-1:0] ax_reg, ax_next;
    logic signed [S-1:0] ay_reg, ay_next;
    logic signed [S-1:0] az_reg, az_next;
    logic                cal_reg, cal_next;
    logic                phase_reg, phase_next;   // 0 roll, 1 pitch

    // configuration and filter state
    logic [W_W-1:0]          new_weight_reg, new_weight_next;
    logic signed [ANG_W-1:0] roll_angle_reg, roll_angle_next;
    logic signed [ANG_W-1:0] pitch_angle_reg, pitch_angle_next;
    logic signed [ANG_W-1:0] roll_offset_reg, roll_offset_next;
    logic signed [ANG_W-1:0] pitch_offset_reg, pitch_offset_next;

    // datapath registers
    logic [SQ_W-1:0]         sq_acc_reg, sq_acc_next;
    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    logic signed [Z_W-1:0]   cz_reg, cz_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic                    zero_reg, zero_next;
    logic signed [BL_W-1:0]  prod_reg, prod_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;

    // operands of the angle in progress
    logic signed [S-1:0]     op_a;       // opposite side
    logic signed [S-1:0]     op_p;       // first adjacent component
    logic signed [ANG_W-1:0] old_ang;
    logic signed [ANG_W-1:0] old_off;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    // square root unit
    logic                    sqrt_start;
    logic [RAD_W-1:0]        sqrt_rad;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       sqrt_root;
    logic [SQ_W-1:0]         sq_sum;

    // cordic step
    logic signed [CW-1:0]    c_dx, c_dy;
    logic signed [Z_W-1:0]   c_atan;

    // blend and finish
    logic [W_W-1:0]          w_eff;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [Z_W-1:0]   z_sh;
    logic signed [ANG_W-1:0] fresh;
    logic signed [ANG_W:0]   bl_diff;
    logic signed [BL_W-1:0]  fin_sum;
    logic signed [BL_W-1:0]  fin_sh;
    logic signed [ANG_W-1:0] off_eff;
    logic signed [DIF_W-1:0] fin_diff;
    logic signed [ANG_W-1:0] fin_ang;

    logic in_fire;

    // roll is atan2(y, |x,z|), pitch is atan2(x, |y,z|)
    assign op_a    = phase_reg ? ax_reg : ay_reg;
    assign op_p    = phase_reg ? ay_reg : ax_reg;
    assign old_ang = phase_reg ? pitch_angle_reg : roll_angle_reg;
    assign old_off = phase_reg ? pitch_offset_reg : roll_offset_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // weights above full scale act as full scale
    assign w_eff = (new_weight_reg > W_MAX) ? W_MAX : new_weight_reg;

    // operand select for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_A: begin
                mul_a = MUL_W'(op_p);
                mul_b = MUL_W'(op_p);
            end
            ST_SQ_B: begin
                mul_a = MUL_W'(az_reg);
                mul_b = MUL_W'(az_reg);
            end
            ST_BLEND: begin
                mul_a = MUL_W'(bl_diff);
                mul_b = MUL_W'($signed({1'b0, w_eff}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sum of squares, scaled by 2^16 before the root
    assign sq_sum     = sq_acc_reg + mul_p[SQ_W-1:0];
    assign sqrt_rad   = {sq_sum, 16'd0};
    assign sqrt_start = (state_reg == ST_SQ_B);

    atf_isqrt #(
        .ROOT_W   (ROOT_W)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // vectoring iteration: drive y toward zero, accumulate the angle
    assign c_dx   = cy_reg >>> step_reg;
    assign c_dy   = cx_reg >>> step_reg;
    assign c_atan = atan_deg(ATAN_IDX_W'(step_reg));

    // round accumulated angle to degrees * 256; both operands zero gives zero
    assign z_rnd   = cz_reg + Z_W'(128);
    assign z_sh    = z_rnd >>> 8;
    assign fresh   = zero_reg ? '0 : z_sh[ANG_W-1:0];
    assign bl_diff = (ANG_W+1)'(fresh) - (ANG_W+1)'(old_ang);

    // w*new + (256-w)*old = 256*old + w*(new-old), rounded
    assign fin_sum  = BL_W'($signed({old_ang, 8'd0})) + prod_reg + BL_W'(128);
    assign fin_sh   = fin_sum >>> 8;
    // calibration measures against a zero offset
    assign off_eff  = cal_reg ? '0 : old_off;
    assign fin_diff = DIF_W'($signed(fin_sh[RND_W-1:0])) - DIF_W'(off_eff);

    always_comb begin
        if (fin_diff > DIF_W'(ANG_LIMIT)) begin
            fin_ang = ANG_W'(ANG_LIMIT);
        end else if (fin_diff < -DIF_W'(ANG_LIMIT)) begin
            fin_ang = -ANG_W'(ANG_LIMIT);
        end else begin
            fin_ang = fin_diff[ANG_W-1:0];
        end
    end

    // sequencer and datapath updates
    always_comb begin
        state_next        = state_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        az_next           = az_reg;
        cal_next          = cal_reg;
        phase_next        = phase_reg;
        new_weight_next   = new_weight_reg;
        roll_angle_next   = roll_angle_reg;
        pitch_angle_next  = pitch_angle_reg;
        roll_offset_next  = roll_offset_reg;
        pitch_offset_next = pitch_offset_reg;
        sq_acc_next       = sq_acc_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        cz_next           = cz_reg;
        step_next         = step_reg;
        zero_next         = zero_reg;
        prod_next         = prod_reg;
        // output transaction frees the register
        m_valid_next      = m_valid_reg && !m_axis_tready;
        m_data_next       = m_data_reg;

        if (cfg_we) begin
            new_weight_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    ax_next    = $signed(s_axis_tdata[S-1:0]);
                    ay_next    = $signed(s_axis_tdata[2*S-1:S]);
                    az_next    = $signed(s_axis_tdata[3*S-1:2*S]);
                    cal_next   = s_axis_tuser;
                    phase_next = 1'b0;
                    state_next = ST_SQ_A;
                end
            end
            ST_SQ_A: begin
                sq_acc_next = mul_p[SQ_W-1:0];
                state_next  = ST_SQ_B;
            end
            ST_SQ_B: begin
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    cx_next    = CW'(sqrt_root);
                    cy_next    = CW'($signed({op_a, 8'd0}));
                    cz_next    = '0;
                    step_next  = '0;
                    zero_next  = (sqrt_root == '0) && (op_a == '0);
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (!cy_reg[CW-1]) begin
                    cx_next = cx_reg + c_dx;
                    cy_next = cy_reg - c_dy;
                    cz_next = cz_reg + c_atan;
                end else begin
                    cx_next = cx_reg - c_dx;
                    cy_next = cy_reg + c_dy;
                    cz_next = cz_reg - c_atan;
                end
                if (step_reg == IDX_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_BLEND;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_BLEND: begin
                prod_next  = mul_p[BL_W-1:0];
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (phase_reg) begin
                    pitch_angle_next = fin_ang;
                    if (cal_reg) begin
                        pitch_offset_next = fin_ang;
                    end
                    state_next = ST_OUT;
                end else begin
                    roll_angle_next = fin_ang;
                    if (cal_reg) begin
                        roll_offset_next = fin_ang;
                    end
                    phase_next = 1'b1;
                    state_next = ST_SQ_A;
                end
            end
            ST_OUT: begin
                // wait here only if the previous pair is still not taken
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({pitch_angle_reg, roll_angle_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            new_weight_reg   <= W_RESET;
            roll_angle_reg   <= '0;
            pitch_angle_reg  <= '0;
            roll_offset_reg  <= '0;
            pitch_offset_reg <= '0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            new_weight_reg   <= new_weight_next;
            roll_angle_reg   <= roll_angle_next;
            pitch_angle_reg  <= pitch_angle_next;
            roll_offset_reg  <= roll_offset_next;
            pitch_offset_reg <= pitch_offset_next;
        end
        // payload, no reset needed
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        cal_reg    <= cal_next;
        phase_reg  <= phase_next;
        sq_acc_reg <= sq_acc_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        step_reg   <= step_next;
        zero_reg   <= zero_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ src/atf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "accel_tilt_angle_filter_macros.svh"

module atf_checker
    import atf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_axis_tvalid,
    input wire logic                                  s_axis_tready,
    input wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    input wire logic                                  s_axis_tuser,
    input wire logic                                  m_axis_tvalid,
    input wire logic                                  m_axis_tready,
    input wire logic [((2*ANG_W+7)/8)*8-1:0]          m_axis_tdata
);

    logic signed [ANG_W-1:0] roll_out;
    logic signed [ANG_W-1:0] pitch_out;
    logic                    in_fire;
    logic                    roll_ok;
    logic                    pitch_ok;

    assign roll_out  = $signed(m_axis_tdata[ANG_W-1:0]);
    assign pitch_out = $signed(m_axis_tdata[2*ANG_W-1:ANG_W]);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign roll_ok   = (roll_out <= ANG_LIMIT) && (roll_out >= -ANG_LIMIT);
    assign pitch_ok  = (pitch_out <= ANG_LIMIT) && (pitch_out >= -ANG_LIMIT);

    // a stalled result holds
    `ATF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // the block works many cycles on a sample
    `ATF_ASSERT(a_busy_after_accept, in_fire |=> !s_axis_tready, "ready right after a sample")

    // a new result only appears from the busy sequence
    `ATF_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without work")

    // both angles stay within the saturation limit
    `ATF_ASSERT(a_angle_range, m_axis_tvalid |-> roll_ok && pitch_ok, "angle out of range")

    // reset drops the output
    `ATF_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_axis_tvalid, "valid after reset")

endmodule

bind accel_tilt_angle_filter atf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_atf_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import atf_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int ITERS       = CORDIC_STEPS_DEF;
    localparam int IN_W        = ((3 * SB + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * ANG_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX  = (1 << (SB - 1)) - 1;
    localparam int SAMPLE_MIN  = -(1 << (SB - 1));
    // long receiver hold, well beyond one sample time so the block backs up
    localparam int HOLD_CYCLES = 3000;
    // somewhat longer than the input-to-output latency of one sample
    localparam int TAIL_CYCLES = 120;
    // watchdog bound, well above the length of the slowest legal run
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic signed [SB-1:0] ax;
        logic signed [SB-1:0] ay;
        logic signed [SB-1:0] az;
        logic                 cal;
    } sample_t;

    typedef struct {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
    } tilt_t;

    // clock, reset and dut ports, the driven ones known from time zero
    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [W_W-1:0]      cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;  // accel_x, accel_y, accel_z, zero pad
    logic                s_axis_tuser  = 1'b0; // calibrate
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;        // roll_deg, pitch_deg, zero pad

    // samples waiting to be sent, and angles waiting to come back
    sample_t pending_samples[$];
    tilt_t   expected_tilts[$];
    sample_t in_flight;

    // shadow of the filter state and the weight register
    logic [W_W-1:0] weight_shadow = W_RESET;
    longint         roll_hist     = 0;
    longint         pitch_hist    = 0;
    longint         roll_zero     = 0;
    longint         pitch_zero    = 0;

    // atan(2^-i) in degrees * 65536
    longint atan_q16[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    int error_count = 0;
    int cycle_count = 0;
    int tx_gap      = 0;
    int tx_calm     = 0;
    int rx_stall    = 0;
    int rx_calm     = 0;
    int hold_left   = 0;
    int hold_req    = 0;
    int hold_seen   = 0;

    accel_tilt_angle_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // angle prediction
    // ---------------------------------------------------------------

    // floor of the square root, digit by digit
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // atan2(opp, sqrt(p^2 + q^2)) in degrees * 256 via vectoring cordic
    function automatic longint tilt_q8(longint opp, longint p, longint q);
        longint cx;
        longint cy;
        longint acc;
        longint dx;
        longint dy;
        cx  = longint'(floor_sqrt(longint'(p * p + q * q) << 16));
        cy  = opp * 256;
        acc = 0;
        // both operands zero: angle is defined as zero
        if (cx == 0 && cy == 0)
            return 0;
        for (int i = 0; i < ITERS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx  = cx + dx;
                cy  = cy - dy;
                acc = acc + atan_q16[i];
            end else begin
                cx  = cx - dx;
                cy  = cy + dy;
                acc = acc - atan_q16[i];
            end
        end
        return (acc + 128) >>> 8;
    endfunction

    // low-pass mix of fresh and stored angle, weights above 256 clamp to 256
    function automatic longint lowpass(longint fresh, longint old);
        longint w;
        w = (weight_shadow > W_MAX) ? 256 : longint'(weight_shadow);
        return (w * fresh + (256 - w) * old + 128) >>> 8;
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > ANG_LIMIT)
            return ANG_LIMIT;
        if (v < -ANG_LIMIT)
            return -ANG_LIMIT;
        return v;
    endfunction

    // advances the shadow state by one sample and returns the angles it gives
    function automatic tilt_t predict_tilt(sample_t s);
        tilt_t  res;
        longint r;
        longint p;
        if (s.cal) begin
            roll_zero  = 0;
            pitch_zero = 0;
        end
        r = lowpass(tilt_q8(longint'(s.ay), longint'(s.ax), longint'(s.az)), roll_hist);
        p = lowpass(tilt_q8(longint'(s.ax), longint'(s.ay), longint'(s.az)), pitch_hist);
        r = clamp_angle(r - roll_zero);
        p = clamp_angle(p - pitch_zero);
        roll_hist  = r;
        pitch_hist = p;
        if (s.cal) begin
            roll_zero  = r;
            pitch_zero = p;
        end
        res.roll  = r[ANG_W-1:0];
        res.pitch = p[ANG_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 50)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 12));
        else
            return int'($urandom_range(20, 60));
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int edge_value();
        case ($urandom_range(0, 4))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return -1;
            3:       return 1;
            default: return 0;
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      kind;
        int      big;
        kind = int'($urandom_range(0, 9));
        case (kind)
            0, 1, 2, 3: begin
                // any raw count
                s.ax = SB'($urandom);
                s.ay = SB'($urandom);
                s.az = SB'($urandom);
            end
            4, 5: begin
                // gravity mostly along one axis, the others near zero
                big  = int'($urandom_range(900, SAMPLE_MAX));
                if ($urandom_range(0, 1))
                    big = -big - 1;
                s.ax = SB'(spread(300));
                s.ay = SB'(spread(300));
                s.az = SB'(spread(300));
                case ($urandom_range(0, 2))
                    0:       s.ax = SB'(big);
                    1:       s.ay = SB'(big);
                    default: s.az = SB'(big);
                endcase
            end
            6: begin
                s.ax = SB'(edge_value());
                s.ay = SB'(edge_value());
                s.az = SB'(edge_value());
            end
            7: begin
                s.ax = SB'(spread(3));
                s.ay = SB'(spread(3));
                s.az = SB'(spread(3));
            end
            default: begin
                s.ax = SB'(spread(1024));
                s.ay = SB'(spread(1024));
                s.az = SB'(spread(1024));
            end
        endcase
        s.cal = ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    task automatic queue_sample(int x, int y, int z, bit cal);
        sample_t s;
        s.ax  = SB'(x);
        s.ay  = SB'(y);
        s.az  = SB'(z);
        s.cal = cal;
        pending_samples.push_back(s);
    endtask

    // sender stays quiet until every sample is out and every angle is back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_tilts.size() != 0);
    endtask

    // register writes happen only with the block idle
    task automatic write_weight(logic [W_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        weight_shadow = value;
    endtask

    // ---------------------------------------------------------------
    // input side: one transaction per sample, random gaps in between
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : sample_sender
        sample_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            // accepted transaction: predict its angles now
            if (s_axis_tvalid && s_axis_tready)
                expected_tilts.push_back(predict_tilt(in_flight));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    nxt = pending_samples.pop_front();
                    in_flight     <= nxt;
                    s_axis_tdata  <= IN_W'({nxt.az, nxt.ay, nxt.ax});
                    s_axis_tuser  <= nxt.cal;
                    s_axis_tvalid <= 1'b1;
                    // calm stretches keep the sender back to back
                    if (tx_calm != 0) begin
                        tx_calm <= tx_calm - 1;
                        tx_gap  <= 0;
                    end else begin
                        if ($urandom_range(0, 149) == 0)
                            tx_calm <= int'($urandom_range(30, 120));
                        tx_gap <= idle_len();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output side: stalls, the long hold, and the angle check
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : tilt_monitor
        tilt_t                   want;
        logic signed [ANG_W-1:0] got_roll;
        logic signed [ANG_W-1:0] got_pitch;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_roll  = m_axis_tdata[ANG_W-1:0];
                got_pitch = m_axis_tdata[2*ANG_W-1:ANG_W];
                if (expected_tilts.size() == 0) begin
                    $error("unexpected transaction: roll_deg %0d pitch_deg %0d",
                           got_roll, got_pitch);
                    error_count++;
                end else begin
                    want = expected_tilts.pop_front();
                    if (got_roll !== want.roll) begin
                        $error("roll_deg: expected %0d, got %0d", want.roll, got_roll);
                        error_count++;
                    end
                    if (got_pitch !== want.pitch) begin
                        $error("pitch_deg: expected %0d, got %0d", want.pitch, got_pitch);
                        error_count++;
                    end
                end
            end
            if (hold_seen != hold_req) begin
                // start of a long hold, the block backs up and stalls its input
                hold_seen     <= hold_req;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall      <= rx_stall - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                // pick the stall that follows this transaction
                if (rx_calm != 0) begin
                    rx_calm       <= rx_calm - 1;
                    m_axis_tready <= 1'b1;
                end else begin
                    if ($urandom_range(0, 149) == 0)
                        rx_calm <= int'($urandom_range(30, 120));
                    rx_stall      <= idle_len();
                    m_axis_tready <= 1'b0;
                end
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("accel_tilt_angle_filter: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    logic [W_W-1:0] weight_plan[9];

    initial begin
        weight_plan = '{9'd0, 9'd511, 9'd1, 9'd128, 9'd255, 9'd257, 9'd0, 9'd200, W_RESET};
        weight_plan[6] = W_W'($urandom_range(0, 511));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset weight: zero operands, axis extremes, calibration
        queue_sample(0, 0, 0, 1'b0);
        queue_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MAX, 0, 0, 1'b0);
        queue_sample(SAMPLE_MIN, 0, 0, 1'b0);
        queue_sample(0, SAMPLE_MAX, 0, 1'b0);
        queue_sample(0, SAMPLE_MIN, 0, 1'b0);
        queue_sample(0, 0, SAMPLE_MAX, 1'b0);
        queue_sample(0, 0, SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MAX, SAMPLE_MIN, 0, 1'b0);
        queue_sample(-1, 1, 0, 1'b0);
        queue_sample(1, -1, -1, 1'b0);
        queue_sample(0, 0, 1000, 1'b1);
        queue_sample(300, -200, 1000, 1'b0);
        queue_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        queue_sample(0, 0, 0, 1'b0);
        wait_drained();

        // full weight: offsets at -90 degrees push the next angle into saturation
        write_weight(W_MAX);
        queue_sample(SAMPLE_MIN, 0, 0, 1'b1);
        queue_sample(SAMPLE_MAX, 0, 0, 1'b0);
        queue_sample(0, SAMPLE_MIN, 0, 1'b1);
        queue_sample(0, SAMPLE_MAX, 0, 1'b0);
        queue_sample(0, SAMPLE_MAX, 0, 1'b0);
        queue_sample(0, 0, 0, 1'b1);
        wait_drained();

        // random phases over a spread of weights
        foreach (weight_plan[k]) begin
            write_weight(weight_plan[k]);
            @(negedge aclk);
            if (k == 2)
                hold_req++;
            repeat (PHASE_ITEMS)
                pending_samples.push_back(random_sample());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_tilts.size() == 0)
            $display("accel_tilt_angle_filter: match");
        else
            $display("accel_tilt_angle_filter: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/atf_pkg.sv
src/atf_isqrt.sv
src/accel_tilt_angle_filter.sv
src/atf_checker.sv
tb/tb_top.sv
